FILE: hw/rtl/cpfsk_pkg.sv
// package for the cpfsk modulator: field widths, register codes, reset values
// and the elaboration-time quarter-wave sine function; depends on nothing
`default_nettype none

package cpfsk_pkg;

	localparam int TUNE_W      = 32;
	localparam int AMP_W       = 16;
	localparam int SPB_W       = 7;
	localparam int SAMPLE_W    = 20;
	localparam int SINE_W      = 15;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	localparam logic [TUNE_W-1:0] TUNE_ZERO_RST = 32'd97391549;
	localparam logic [TUNE_W-1:0] TUNE_ONE_RST  = 32'd194783097;
	localparam logic [AMP_W-1:0]  AMP_ZERO_RST  = 16'd4096;
	localparam logic [AMP_W-1:0]  AMP_ONE_RST   = 16'd40960;
	localparam logic [SPB_W-1:0]  SPB_RST       = 7'd44;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_TUNE_ZERO = 3'd0,
		REG_TUNE_ONE  = 3'd1,
		REG_AMP_ZERO  = 3'd2,
		REG_AMP_ONE   = 3'd3,
		REG_SPB       = 3'd4
	} cfg_reg_t;

	// sin(r * (pi/2) / 2^(tbits-2)) in Q0.15, taylor series to x^15 in Q30
	function automatic logic [SINE_W-1:0] quarter_sine(input logic [63:0] r,
		input int tbits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint      sum;
		logic [63:0] rnd;
		x    = (r * HALF_PI_Q30 + ((64'd1 << (tbits - 2)) >> 1)) >> (tbits - 2);
		x2   = (x * x) >> 30;
		sum  = longint'(x);
		term = ((x * x2) >> 30) / 64'd6;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd210;
		sum  = sum - longint'(term);
		if (sum < 0) begin
			sum = 0;
		end
		rnd = (64'(sum) + 64'd16384) >> 15;
		if (rnd > 64'd32767) begin
			rnd = 64'd32767;
		end
		return rnd[SINE_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cpfsk_if.sv
// valid/ready channel interfaces for data bits in and audio samples out
// depends on cpfsk_pkg for the sample width
`default_nettype none

interface cpfsk_bit_if;
	logic valid;
	logic ready;
	logic data_bit;
	logic restart_phase;

	modport source (output valid, output data_bit, output restart_phase, input ready);
	modport sink (input valid, input data_bit, input restart_phase, output ready);
endinterface

interface cpfsk_smp_if;
	logic                              valid;
	logic                              ready;
	logic signed [cpfsk_pkg::SAMPLE_W-1:0] sample;
	logic                              last_of_bit;

	modport source (output valid, output sample, output last_of_bit, input ready);
	modport sink (input valid, input sample, input last_of_bit, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/cpfsk_front.sv
// front end: configuration registers, bit transfer and descriptor build
// depends on cpfsk_pkg and cpfsk_bit_if
`default_nettype none

module cpfsk_front #(
	parameter int PHASE_BITS          = 32,
	parameter int MAX_SAMPLES_PER_BIT = 64,
	parameter int CNT_W               = 7,
	parameter int DESC_W              = 1 + 7 + 16 + 32
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire  [cpfsk_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire  [cpfsk_pkg::CFG_DATA_W-1:0]     cfg_data,
	cpfsk_bit_if.sink                            data,
	input  wire                                  push_ready,
	output logic                                 push_valid,
	output logic [DESC_W-1:0]                    push_data
);

	logic [cpfsk_pkg::TUNE_W-1:0] tune_zero_q;
	logic [cpfsk_pkg::TUNE_W-1:0] tune_one_q;
	logic [cpfsk_pkg::AMP_W-1:0]  amp_zero_q;
	logic [cpfsk_pkg::AMP_W-1:0]  amp_one_q;
	logic [cpfsk_pkg::SPB_W-1:0]  spb_q;

	logic [PHASE_BITS-1:0]        inc;
	logic [cpfsk_pkg::AMP_W-1:0]  amp;
	logic [CNT_W-1:0]             cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tune_zero_q <= cpfsk_pkg::TUNE_ZERO_RST;
			tune_one_q  <= cpfsk_pkg::TUNE_ONE_RST;
			amp_zero_q  <= cpfsk_pkg::AMP_ZERO_RST;
			amp_one_q   <= cpfsk_pkg::AMP_ONE_RST;
			spb_q       <= cpfsk_pkg::SPB_RST;
		end else if (cfg_we) begin
			case (cpfsk_pkg::cfg_reg_t'(cfg_index))
				cpfsk_pkg::REG_TUNE_ZERO: tune_zero_q <= cfg_data;
				cpfsk_pkg::REG_TUNE_ONE:  tune_one_q  <= cfg_data;
				cpfsk_pkg::REG_AMP_ZERO:  amp_zero_q  <= cfg_data[cpfsk_pkg::AMP_W-1:0];
				cpfsk_pkg::REG_AMP_ONE:   amp_one_q   <= cfg_data[cpfsk_pkg::AMP_W-1:0];
				cpfsk_pkg::REG_SPB:       spb_q       <= cfg_data[cpfsk_pkg::SPB_W-1:0];
				default: ;
			endcase
		end
	end

	// tone, amplitude and clamped sample count for the incoming bit
	always_comb begin
		inc = data.data_bit ? PHASE_BITS'(tune_one_q) : PHASE_BITS'(tune_zero_q);
		amp = data.data_bit ? amp_one_q : amp_zero_q;
		if (spb_q == '0) begin
			cnt = CNT_W'(1);
		end else if (int'(spb_q) > MAX_SAMPLES_PER_BIT) begin
			cnt = CNT_W'(MAX_SAMPLES_PER_BIT);
		end else begin
			cnt = CNT_W'(spb_q);
		end
	end

	assign data.ready = push_ready;
	assign push_valid = data.valid;
	assign push_data  = {data.restart_phase, cnt, amp, inc};

endmodule

`default_nettype wire

FILE: hw/rtl/cpfsk_queue.sv
// small descriptor fifo between front and back ends
// self contained, no package use
`default_nettype none

module cpfsk_queue #(
	parameter int WIDTH = 56,
	parameter int DEPTH = 2
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push_valid,
	output logic             push_ready,
	input  wire [WIDTH-1:0]  push_data,
	output logic             pop_valid,
	input  wire              pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/cpfsk_back.sv
// back end: per-sample phase accumulator, sine lookup, scaling and rounding
// depends on cpfsk_pkg and cpfsk_smp_if
`default_nettype none

module cpfsk_back #(
	parameter int PHASE_BITS      = 32,
	parameter int SINE_TABLE_BITS = 10,
	parameter int CNT_W           = 7,
	parameter int DESC_W          = 1 + 7 + 16 + 32
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               pop_valid,
	output logic              pop_ready,
	input  wire [DESC_W-1:0]  pop_data,
	cpfsk_smp_if.source       audio
);

	localparam int AMP_W   = cpfsk_pkg::AMP_W;
	localparam int SINE_W  = cpfsk_pkg::SINE_W;
	localparam int ADDR_W  = SINE_TABLE_BITS - 1;
	localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
	localparam int PROD_W  = 2 * (SINE_W + 2) - 1;

	// quarter-wave table, entries 0..QUARTER inclusive
	logic [SINE_W-1:0] sine_rom [QUARTER + 1];

	for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
		assign sine_rom[k] = cpfsk_pkg::quarter_sine(64'(k), SINE_TABLE_BITS);
	end

	logic [PHASE_BITS-1:0] head_inc;
	logic [AMP_W-1:0]      head_amp;
	logic [CNT_W-1:0]      head_cnt;
	logic                  head_restart;

	logic                  busy_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [PHASE_BITS-1:0] inc_q;
	logic [AMP_W-1:0]      amp_q;

	logic                  en;
	logic                  start;
	logic                  issue;
	logic [PHASE_BITS-1:0] sel_inc;
	logic [AMP_W-1:0]      sel_amp;
	logic [CNT_W-1:0]      remaining;
	logic                  issue_last;
	logic [PHASE_BITS-1:0] phase_base;

	// stage 1: phase
	logic                  vld_s1;
	logic [PHASE_BITS-1:0] phase_q;
	logic [AMP_W-1:0]      amp_s1;
	logic                  last_s1;

	logic [SINE_TABLE_BITS-1:0] idx;
	logic [ADDR_W-1:0]          rom_addr;

	// stage 2: table read
	logic              vld_s2;
	logic [SINE_W-1:0] rom_s2;
	logic              neg_s2;
	logic [AMP_W-1:0]  amp_s2;
	logic              last_s2;

	// stage 3: product
	logic                     vld_s3;
	logic signed [PROD_W-1:0] prod_s3;
	logic                     last_s3;
	logic signed [PROD_W-1:0] rounded;

	// stage 4: output register
	logic                                  vld_s4;
	logic signed [cpfsk_pkg::SAMPLE_W-1:0] sample_s4;
	logic                                  last_s4;

	assign head_inc     = pop_data[PHASE_BITS-1:0];
	assign head_amp     = pop_data[PHASE_BITS +: AMP_W];
	assign head_cnt     = pop_data[PHASE_BITS + AMP_W +: CNT_W];
	assign head_restart = pop_data[DESC_W-1];

	assign en    = !vld_s4 || audio.ready;
	assign start = !busy_q && pop_valid;
	assign issue = en && (busy_q || pop_valid);
	assign pop_ready = en && !busy_q;

	always_comb begin
		sel_inc    = busy_q ? inc_q : head_inc;
		sel_amp    = busy_q ? amp_q : head_amp;
		remaining  = busy_q ? cnt_q : head_cnt;
		issue_last = (remaining == CNT_W'(1));
		phase_base = (start && head_restart) ? '0 : phase_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			phase_q <= '0;
		end else if (issue) begin
			busy_q  <= !issue_last;
			cnt_q   <= remaining - 1'b1;
			phase_q <= phase_base + sel_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (issue && start) begin
			inc_q <= head_inc;
			amp_q <= head_amp;
		end
	end

	// quadrant fold of the table index
	always_comb begin
		idx = phase_q[PHASE_BITS-1 -: SINE_TABLE_BITS];
		if (idx[SINE_TABLE_BITS-2]) begin
			rom_addr = ADDR_W'(QUARTER) - {1'b0, idx[SINE_TABLE_BITS-3:0]};
		end else begin
			rom_addr = {1'b0, idx[SINE_TABLE_BITS-3:0]};
		end
		rounded = prod_s3 + PROD_W'(4096);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			amp_s1    <= sel_amp;
			last_s1   <= issue_last;
			rom_s2    <= sine_rom[rom_addr];
			neg_s2    <= idx[SINE_TABLE_BITS-1];
			amp_s2    <= amp_s1;
			last_s2   <= last_s1;
			prod_s3   <= (neg_s2 ? -$signed({2'b00, rom_s2}) : $signed({2'b00, rom_s2}))
				* $signed({1'b0, amp_s2});
			last_s3   <= last_s2;
			sample_s4 <= rounded[PROD_W-1 -: cpfsk_pkg::SAMPLE_W];
			last_s4   <= last_s3;
		end
	end

	assign audio.valid       = vld_s4;
	assign audio.sample      = sample_s4;
	assign audio.last_of_bit = last_s4;

`ifndef SYNTHESIS
	// an active bit always has samples left to issue
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0)
		else $error("busy with zero remaining samples");

	// the last sample of a bit frees the generator for the next descriptor
	assert property (@(posedge clk) disable iff (!arst_n)
		issue && issue_last |=> !busy_q)
		else $error("generator still busy after last sample");

	// a frame start restarts the phase from zero
	assert property (@(posedge clk) disable iff (!arst_n)
		issue && start && head_restart |=> phase_q == $past(head_inc))
		else $error("phase not restarted at frame start");

	// no descriptor is taken while a bit is still being generated
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !pop_ready)
		else $error("descriptor popped during an active bit");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/cpfsk_modulator_preemphasis.sv
// data path: descriptor queue, then phase, table read, product and output registers
// throughput: one sample per cycle from the phase accumulator loop unless audio.ready
//   holds it; samples_per_bit per bit (0 counts as 1, capped at MAX_SAMPLES_PER_BIT)
// reset: config registers take their default tones, amplitudes and count, phase clears
//   to zero, the descriptor queue and the sample pipeline empty
// depends on cpfsk_pkg, cpfsk_if, cpfsk_front, cpfsk_queue, cpfsk_back
`default_nettype none

module cpfsk_modulator_preemphasis #(
	parameter int PHASE_BITS          = 32,
	parameter int SINE_TABLE_BITS     = 10,
	parameter int MAX_SAMPLES_PER_BIT = 64
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire [cpfsk_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire [cpfsk_pkg::CFG_DATA_W-1:0]   cfg_data,
	cpfsk_bit_if.sink                         data,
	cpfsk_smp_if.source                       audio
);

	// sample count per bit, wide enough to hold the cap itself
	localparam int CNT_W       = $clog2(MAX_SAMPLES_PER_BIT + 1);
	// descriptor layout: restart flag, sample count, amplitude, phase increment
	localparam int DESC_W      = 1 + CNT_W + cpfsk_pkg::AMP_W + PHASE_BITS;
	// two entries let the front take the next bit while the back runs the current one
	localparam int QUEUE_DEPTH = 2;

	logic              push_valid;
	logic              push_ready;
	logic [DESC_W-1:0] push_data;
	logic              pop_valid;
	logic              pop_ready;
	logic [DESC_W-1:0] pop_data;

	// front: register writes, bit transfer, tone and amplitude selection
	cpfsk_front #(
		.PHASE_BITS          (PHASE_BITS),
		.MAX_SAMPLES_PER_BIT (MAX_SAMPLES_PER_BIT),
		.CNT_W               (CNT_W),
		.DESC_W              (DESC_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.data       (data),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_data  (push_data)
	);

	// descriptor queue decouples bit transfers from sample generation
	cpfsk_queue #(
		.WIDTH (DESC_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// back: phase accumulate, table read, multiply, round; stalls as a whole on audio.ready
	cpfsk_back #(
		.PHASE_BITS      (PHASE_BITS),
		.SINE_TABLE_BITS (SINE_TABLE_BITS),
		.CNT_W           (CNT_W),
		.DESC_W          (DESC_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.audio     (audio)
	);

endmodule

`default_nettype wire
